### design/ted_pkg.sv
// ted_pkg: constants, types and helper functions of the text entity decoder
// depends on nothing; used by every other file of the block but the two interfaces
`timescale 1ns / 1ps

package ted_pkg;

    // entity window: '&' plus up to ENTITY_SPAN more bytes
    localparam int ENTITY_SPAN = 12;
    localparam int WIN_DEPTH   = ENTITY_SPAN + 1;
    localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
    // circular byte buffer holding the window and pending replay bytes
    localparam int BUF_AW      = FILL_W;
    localparam int BUF_DEPTH   = 1 << BUF_AW;
    // input queue between front and back
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    // numeric value, saturating at VALUE_CAP
    localparam int VAL_W       = 17;
    localparam logic [VAL_W-1:0] VALUE_CAP = 17'h10000;
    localparam int ACC_W       = VAL_W + 4;
    // named entity table
    localparam int NAME_COUNT  = 13;
    localparam int NAME_MAX    = 6;

    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;

    typedef struct packed {
        logic       amp;
        logic       semi;
        logic       space;
        logic       hash;
        logic       xx;
        logic       sign;
        logic       minus;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] dval;
    } t_cls;

    typedef struct packed {
        logic [7:0] data;
        t_cls       cls;
    } t_tok;

    typedef struct packed {
        t_tok tok;
        logic last;
    } t_qitem;

    // replacement: cnt copies of data (cnt zero means nothing)
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] cnt;
    } t_emit;

    typedef enum logic [2:0] {
        NUM_HEAD,
        NUM_NONE,
        NUM_START,
        NUM_WS,
        NUM_DIG,
        NUM_PFX,
        NUM_STOP
    } t_num_phase;

    function automatic t_cls classify(logic [7:0] b);
        t_cls c;
        c.amp    = (b == CH_AMP);
        c.semi   = (b == CH_SEMI);
        c.space  = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
        c.hash   = (b == CH_HASH);
        c.xx     = (b == CH_LOW_X) || (b == CH_UP_X);
        c.sign   = (b == CH_PLUS) || (b == CH_MINUS);
        c.minus  = (b == CH_MINUS);
        c.dec_ok = (b >= 8'h30 && b <= 8'h39);
        c.hex_ok = c.dec_ok || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
        if (c.dec_ok) begin
            c.dval = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            c.dval = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            c.dval = 4'(b - 8'h37);
        end else begin
            c.dval = 4'd0;
        end
        return c;
    endfunction

    function automatic logic [8*NAME_MAX-1:0] name_str(int unsigned idx);
        logic [8*NAME_MAX-1:0] s;
        unique case (idx)
            0:       s = {"amp", 24'h0};
            1:       s = {"lt", 32'h0};
            2:       s = {"gt", 32'h0};
            3:       s = {"quot", 16'h0};
            4:       s = {"apos", 16'h0};
            5:       s = {"nbsp", 16'h0};
            6:       s = "hellip";
            7:       s = {"mdash", 8'h0};
            8:       s = {"ndash", 8'h0};
            9:       s = {"lsquo", 8'h0};
            10:      s = {"rsquo", 8'h0};
            11:      s = {"ldquo", 8'h0};
            12:      s = {"rdquo", 8'h0};
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] name_len(int unsigned idx);
        logic [3:0] n;
        unique case (idx)
            0:              n = 4'd3;
            1, 2:           n = 4'd2;
            3, 4, 5:        n = 4'd4;
            6:              n = 4'd6;
            7, 8, 9, 10,
            11, 12:         n = 4'd5;
            default:        n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] name_char(int unsigned idx, logic [FILL_W-1:0] k);
        logic [8*NAME_MAX-1:0] s;
        logic [7:0]            c;
        s = name_str(idx);
        c = 8'h0;
        for (int i = 0; i < NAME_MAX; i++) begin
            if (int'(k) == i) begin
                c = s[8*(NAME_MAX-1-i) +: 8];
            end
        end
        return c;
    endfunction

    function automatic t_emit name_text(int unsigned idx);
        t_emit e;
        unique case (idx)
            0:       e = '{data: CH_AMP,    cnt: 2'd1};
            1:       e = '{data: CH_LT,     cnt: 2'd1};
            2:       e = '{data: CH_GT,     cnt: 2'd1};
            3:       e = '{data: CH_DQUOTE, cnt: 2'd1};
            4:       e = '{data: CH_APOS,   cnt: 2'd1};
            5:       e = '{data: CH_SPACE,  cnt: 2'd1};
            6:       e = '{data: CH_DOT,    cnt: 2'd3};
            7:       e = '{data: CH_MINUS,  cnt: 2'd2};
            8:       e = '{data: CH_MINUS,  cnt: 2'd1};
            9, 10:   e = '{data: CH_APOS,   cnt: 2'd1};
            11, 12:  e = '{data: CH_DQUOTE, cnt: 2'd1};
            default: e = '{data: 8'h0,      cnt: 2'd0};
        endcase
        return e;
    endfunction

    function automatic t_emit map_value(logic [VAL_W-1:0] v);
        t_emit e;
        e = '{data: 8'h0, cnt: 2'd0};
        if (v >= 17'h20 && v <= 17'h7E) begin
            e = '{data: v[7:0], cnt: 2'd1};
        end else if (v == 17'h2018 || v == 17'h2019) begin
            e = '{data: CH_APOS, cnt: 2'd1};
        end else if (v == 17'h201C || v == 17'h201D) begin
            e = '{data: CH_DQUOTE, cnt: 2'd1};
        end else if (v == 17'h2013) begin
            e = '{data: CH_MINUS, cnt: 2'd1};
        end else if (v == 17'h2014) begin
            e = '{data: CH_MINUS, cnt: 2'd2};
        end else if (v == 17'h2026) begin
            e = '{data: CH_DOT, cnt: 2'd3};
        end else if (v == 17'hA0) begin
            e = '{data: CH_SPACE, cnt: 2'd1};
        end
        return e;
    endfunction

endpackage

### design/ted_in_if.sv
// ted_in_if: input channel of the text entity decoder, one text byte per word
// depends on nothing
`timescale 1ns / 1ps

interface ted_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

### design/ted_out_if.sv
// ted_out_if: output channel of the text entity decoder, one decoded byte per word
// depends on nothing
`timescale 1ns / 1ps

interface ted_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       text_done;

    modport source (output valid, output out_byte, output byte_valid, output text_done,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input text_done,
                    output ready);
endinterface

### design/ted_front.sv
// ted_front: accepts input words and classifies each byte for the back end
// depends on ted_pkg and ted_in_if
`timescale 1ns / 1ps

module ted_front (
    ted_in_if.sink           i_in,
    input  logic             i_q_full,
    output logic             o_q_push,
    output ted_pkg::t_qitem  o_q_item
);
    import ted_pkg::*;

    assign i_in.ready         = !i_q_full;
    assign o_q_push           = i_in.valid && !i_q_full;
    assign o_q_item.tok.data  = i_in.text_byte;
    assign o_q_item.tok.cls   = classify(i_in.text_byte);
    assign o_q_item.last      = i_in.end_of_text;

endmodule

### design/ted_queue.sv
// ted_queue: short fifo of classified bytes between front and back
// depends on ted_pkg
`timescale 1ns / 1ps

module ted_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ted_pkg::t_qitem  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output ted_pkg::t_qitem  o_item
);
    import ted_pkg::*;

    t_qitem          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_head;
    logic [Q_AW-1:0] r_tail;
    logic [Q_AW:0]   r_cnt;
    logic            push_ok;
    logic            pop_ok;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_head];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_tail] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (push_ok) begin
                r_tail <= r_tail + 1'b1;
            end
            if (pop_ok) begin
                r_head <= r_head + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(push_ok) - (Q_AW+1)'(pop_ok);
        end
    end

endmodule

### design/ted_back.sv
// ted_back: entity window, replay, numeric and named matching, output register
// depends on ted_pkg and ted_out_if
`timescale 1ns / 1ps

module ted_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  ted_pkg::t_qitem  i_q_item,
    output logic             o_q_pop,
    ted_out_if.source        o_out
);
    import ted_pkg::*;

    t_tok              r_buf [BUF_DEPTH];
    logic [BUF_AW-1:0] r_ws, n_ws;
    logic [BUF_AW-1:0] r_rp, n_rp;
    logic [BUF_AW-1:0] r_tail, n_tail;
    logic              r_wopen, n_wopen;
    logic [FILL_W-1:0] r_wfill, n_wfill;
    logic              r_last, n_last;
    logic [NAME_COUNT-1:0] r_cand, n_cand;
    t_num_phase        r_phase, n_phase;
    logic              r_hex, n_hex;
    logic              r_neg, n_neg;
    logic              r_pfx, n_pfx;
    logic [1:0]        r_ndig, n_ndig;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [1:0]        r_em_cnt, n_em_cnt;
    logic [7:0]        r_em_byte, n_em_byte;
    logic              r_pv, n_pv;
    logic [7:0]        r_pb, n_pb;
    logic              r_ov, n_ov;
    logic [7:0]        r_ob, n_ob;
    logic              r_obv, n_obv;
    logic              r_od, n_od;

    logic              out_can;
    logic              do_emq, do_proc, do_take, do_fail_end, do_finish;
    logic              step_final;
    t_tok              tok;
    logic [BUF_AW-1:0] pos;
    logic              em_v;
    logic [7:0]        em_b;
    t_emit             rep;
    logic              fail;
    logic              hit;
    logic [FILL_W-1:0] k;
    logic              base_hex;
    logic              dig_ok;
    logic [ACC_W-1:0]  acc;
    logic [VAL_W-1:0]  acc_cap;

    assign out_can = !r_ov || o_out.ready;
    assign o_q_pop = do_take;

    always_ff @(posedge i_clk) begin
        if (do_take) begin
            r_buf[r_tail] <= i_q_item.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws     <= '0;
            r_rp     <= '0;
            r_tail   <= '0;
            r_wopen  <= 1'b0;
            r_wfill  <= '0;
            r_last   <= 1'b0;
            r_phase  <= NUM_HEAD;
            r_em_cnt <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_ws     <= n_ws;
            r_rp     <= n_rp;
            r_tail   <= n_tail;
            r_wopen  <= n_wopen;
            r_wfill  <= n_wfill;
            r_last   <= n_last;
            r_phase  <= n_phase;
            r_em_cnt <= n_em_cnt;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand    <= n_cand;
        r_hex     <= n_hex;
        r_neg     <= n_neg;
        r_pfx     <= n_pfx;
        r_ndig    <= n_ndig;
        r_val     <= n_val;
        r_em_byte <= n_em_byte;
        r_pb      <= n_pb;
        r_ob      <= n_ob;
        r_obv     <= n_obv;
        r_od      <= n_od;
    end

    always_comb begin
        n_ws = r_ws;   n_rp = r_rp;   n_tail = r_tail;
        n_wopen = r_wopen; n_wfill = r_wfill; n_last = r_last;
        n_cand = r_cand; n_phase = r_phase; n_hex = r_hex; n_neg = r_neg;
        n_pfx = r_pfx; n_ndig = r_ndig; n_val = r_val;
        n_em_cnt = r_em_cnt; n_em_byte = r_em_byte;
        n_pv = r_pv; n_pb = r_pb;
        n_ov = r_ov; n_ob = r_ob; n_obv = r_obv; n_od = r_od;
        em_v = 1'b0; em_b = 8'h0; rep = '{data: 8'h0, cnt: 2'd0};
        fail = 1'b0; hit = 1'b0;

        // one action per cycle, highest priority first
        do_emq      = out_can && (r_em_cnt != '0);
        do_proc     = 1'b0;
        do_take     = 1'b0;
        do_fail_end = 1'b0;
        do_finish   = 1'b0;
        if (out_can && r_em_cnt == '0) begin
            if (r_rp != r_tail) begin
                do_proc = 1'b1;
            end else if (r_last && r_wopen) begin
                do_fail_end = 1'b1;
            end else if (r_last) begin
                do_finish = 1'b1;
            end else if (i_q_valid) begin
                do_take = 1'b1;
                do_proc = 1'b1;
            end
        end
        step_final = do_take ? i_q_item.last : r_last;
        tok = do_take ? i_q_item.tok : r_buf[r_rp];
        pos = do_take ? r_tail : r_rp;
        k   = r_wfill - 1'b1;

        // numeric digit accumulate
        base_hex = (r_phase == NUM_START) ? 1'b0 : r_hex;
        dig_ok   = base_hex ? tok.cls.hex_ok : tok.cls.dec_ok;
        if (base_hex) begin
            acc = {r_val, 4'h0} + ACC_W'(tok.cls.dval);
        end else begin
            acc = ACC_W'({r_val, 3'b0}) + ACC_W'({r_val, 1'b0}) + ACC_W'(tok.cls.dval);
        end
        acc_cap = (acc > ACC_W'(VALUE_CAP)) ? VALUE_CAP : acc[VAL_W-1:0];

        if (do_emq) begin
            em_v     = 1'b1;
            em_b     = r_em_byte;
            n_em_cnt = r_em_cnt - 1'b1;
        end

        if (do_proc) begin
            n_rp = pos + 1'b1;
            if (do_take) begin
                n_tail = r_tail + 1'b1;
                n_last = i_q_item.last;
            end
            if (!r_wopen) begin
                if (tok.cls.amp) begin
                    n_wopen = 1'b1;
                    n_ws    = pos;
                    n_wfill = FILL_W'(1);
                    n_cand  = '1;
                    n_phase = NUM_HEAD;
                    n_hex   = 1'b0;
                    n_neg   = 1'b0;
                    n_pfx   = 1'b0;
                    n_ndig  = '0;
                    n_val   = '0;
                end else begin
                    em_v = 1'b1;
                    em_b = tok.data;
                end
            end else begin
                n_wfill = r_wfill + 1'b1;
                if (tok.cls.semi) begin
                    for (int n = 0; n < NAME_COUNT; n++) begin
                        if (r_cand[n] && FILL_W'(name_len(n)) == k) begin
                            hit = 1'b1;
                            rep = name_text(n);
                        end
                    end
                    if (hit) begin
                        n_wopen = 1'b0;
                    end else if (r_phase != NUM_HEAD && r_phase != NUM_NONE) begin
                        n_wopen = 1'b0;
                        rep     = r_neg ? '{data: 8'h0, cnt: 2'd0} : map_value(r_val);
                    end else begin
                        fail = 1'b1;
                    end
                end else begin
                    for (int n = 0; n < NAME_COUNT; n++) begin
                        n_cand[n] = r_cand[n] && (k < FILL_W'(name_len(n)))
                                    && (name_char(n, k) == tok.data);
                    end
                    unique case (r_phase)
                        NUM_HEAD: begin
                            n_phase = tok.cls.hash ? NUM_START : NUM_NONE;
                        end
                        NUM_START, NUM_WS: begin
                            if (r_phase == NUM_START && tok.cls.xx) begin
                                n_hex   = 1'b1;
                                n_phase = NUM_WS;
                            end else begin
                                n_hex = base_hex;
                                if (tok.cls.space) begin
                                    n_phase = NUM_WS;
                                end else if (tok.cls.sign) begin
                                    n_neg   = tok.cls.minus;
                                    n_phase = NUM_DIG;
                                end else if (dig_ok) begin
                                    n_val   = acc_cap;
                                    n_ndig  = 2'd1;
                                    n_phase = NUM_DIG;
                                end else begin
                                    n_phase = NUM_STOP;
                                end
                            end
                        end
                        NUM_DIG: begin
                            if (dig_ok) begin
                                n_val  = acc_cap;
                                n_ndig = (r_ndig == 2'd3) ? r_ndig : r_ndig + 1'b1;
                            end else if (tok.cls.xx && r_hex && r_ndig == 2'd1
                                         && r_val == '0 && !r_pfx) begin
                                n_pfx   = 1'b1;
                                n_phase = NUM_PFX;
                            end else begin
                                n_phase = NUM_STOP;
                            end
                        end
                        NUM_PFX: begin
                            if (tok.cls.hex_ok) begin
                                n_val   = acc_cap;
                                n_ndig  = 2'd2;
                                n_phase = NUM_DIG;
                            end else begin
                                n_phase = NUM_STOP;
                            end
                        end
                        NUM_NONE, NUM_STOP: begin
                            n_phase = r_phase;
                        end
                        default: begin
                            n_phase = NUM_STOP;
                        end
                    endcase
                    if (r_wfill + 1'b1 == FILL_W'(WIN_DEPTH)) begin
                        fail = 1'b1;
                    end
                end
            end
        end

        if (do_fail_end) begin
            fail = 1'b1;
        end

        // failed window: emit the '&' and rescan what follows it
        if (fail) begin
            em_v    = 1'b1;
            em_b    = CH_AMP;
            n_wopen = 1'b0;
            n_rp    = r_ws + 1'b1;
        end

        if (rep.cnt != '0) begin
            em_v      = 1'b1;
            em_b      = rep.data;
            n_em_cnt  = rep.cnt - 1'b1;
            n_em_byte = rep.data;
        end

        if (!r_ov || o_out.ready) begin
            n_ov = 1'b0;
        end

        // in a final step the latest byte is held back to carry the done flag
        if (em_v) begin
            if (step_final) begin
                if (r_pv) begin
                    n_ov = 1'b1; n_ob = r_pb; n_obv = 1'b1; n_od = 1'b0;
                end
                n_pv = 1'b1;
                n_pb = em_b;
            end else begin
                n_ov = 1'b1; n_ob = em_b; n_obv = 1'b1; n_od = 1'b0;
            end
        end

        if (do_finish) begin
            n_ov   = 1'b1;
            n_ob   = r_pv ? r_pb : 8'h0;
            n_obv  = r_pv;
            n_od   = 1'b1;
            n_pv   = 1'b0;
            n_last = 1'b0;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_ob;
    assign o_out.byte_valid = r_obv;
    assign o_out.text_done  = r_od;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wfill <= FILL_W'(WIN_DEPTH))
        else $error("window fill beyond span");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wopen |-> (BUF_AW'(r_tail - r_ws) <= BUF_AW'(WIN_DEPTH)))
        else $error("held bytes exceed the window");

    a_no_take_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_em_cnt != '0) |-> !do_take)
        else $error("new byte taken during a multi-byte replacement");

    a_finish_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_finish |=> (r_ov && r_od && !r_pv && !r_last))
        else $error("closing word of a text not issued");

endmodule

### design/text_entity_decoder.sv
// text_entity_decoder: top level, html-style entity decoder for a byte stream
// depends on ted_pkg, ted_in_if, ted_out_if, ted_front, ted_queue, ted_back
`timescale 1ns / 1ps

// usage
//   i_in carries one text byte per word with end_of_text on the final byte of a text
//   o_out carries one decoded byte per word; the last word caused by a final byte has
//   text_done set, and a final byte that yields nothing gives one word with
//   byte_valid low
//   a plain byte passes the queue register, then the output register, on its way
//   to o_out; plain text flows at one byte per cycle while the receiver takes every
//   word and no replacement or rescan is pending; an entity replacement goes out
//   one byte per word through the single output register of the back end
//   a failed entity emits the '&', then rescans its held bytes from the window
//   buffer; after a final byte, each entity still open at the end of the text fails
//   the same way, and a closing word ends the text
//   while the receiver stalls, the output register holds its word, the back end
//   stops, and the input queue absorbs up to four words before i_in.ready drops
//   reset clears the queue, the window and the output register; window bytes
//   themselves need no clearing since only written entries are replayed
module text_entity_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ted_in_if.sink    i_in,
    ted_out_if.source o_out
);
    import ted_pkg::*;

    // front to queue
    logic   q_push;
    t_qitem q_in_item;
    logic   q_full;
    // queue to back
    logic   q_valid;
    t_qitem q_out_item;
    logic   q_pop;

    ted_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_in_item)
    );

    ted_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    // window, replay and decode all live in the back end
    ted_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_out_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

### tb/sv/tb_text_entity_decoder.sv
// tb_text_entity_decoder: self-checking bench for the text entity decoder
// depends on ted_pkg, ted_in_if, ted_out_if and text_entity_decoder
`timescale 1ns / 1ps

module tb_text_entity_decoder;
    import ted_pkg::*;

    localparam int STALL_LIMIT = 3000;  // idle cycles before the watchdog trips
    localparam int RAND_ITEMS  = 80;
    localparam int LONG_HOLD   = 300;   // receiver hold-off, fills the input queue
    localparam int MAX_WORDS   = 14;    // most words one text byte can cause

    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       done;
    } t_word;

    // directed texts; a row with a typed answer is checked against it alone
    typedef struct {
        string txt;
        bit    typed;
        string want;
    } t_dir_row;

    localparam int N_DIR = 10;
    t_dir_row dir_rows[N_DIR] = '{
        '{"\001",                                  1, "\001"},
        '{"\377",                                  1, "\377"},
        '{"&amp;&lt;&gt;&quot;&apos;&nbsp;",       1, "&<>\"' "},
        '{"&hellip;&mdash;&ndash;&lsquo;&rsquo;&ldquo;&rdquo;", 0, ""},
        '{"&#65;&#x41;&#X2014;&# -5;&#x0x26;&#99999;&#;", 0, ""},
        '{"&#xa0;&#8217;&#+8220;&#\t8211;&#x2026;", 0, ""},
        '{"&foo;",                                 1, "&foo;"},
        '{"&abcdefghijklm;q",                      0, ""},
        '{"x&am",                                  1, "x&am"},
        '{"&#0;",                                  1, ""}
    };

    string ent_names[13] = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "hellip",
                             "mdash", "ndash", "lsquo", "rsquo", "ldquo", "rdquo"};
    string ent_texts[13] = '{"&", "<", ">", "\"", "'", " ", "...",
                             "--", "-", "'", "'", "\"", "\""};

    logic i_clk;
    logic i_rst_n;

    ted_in_if  in_if ();
    ted_out_if out_if ();

    text_entity_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state: entity window and rescan queue
    logic [7:0] ent_win[WIN_DEPTH];
    int         ent_fill;
    logic [7:0] rescan_q[WIN_DEPTH];
    int         rescan_cnt;
    t_word      step_words[$];      // words caused by the current byte
    t_word      expected_words[$];  // words still owed by the block

    int  error_count;
    int  words_seen;
    int  row_sel;                   // directed row of the word on the bus, -1 if random
    int  typed_row;                 // row of the last accepted word
    bit  burst;                     // both sides run with no gaps
    int  idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic void put_byte(logic [7:0] b);
        t_word w;
        if (step_words.size() >= MAX_WORDS) return;
        w.data = b;
        w.valid = 1'b1;
        w.done = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic int digit_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 99;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // strtol-like parse of window bytes [st, st+len), saturating at the cap
    function automatic int unsigned read_number(int st, int len, int base, output bit neg);
        int          i;
        int unsigned v;
        i = 0;
        v = 0;
        neg = 0;
        while (i < len && is_blank(ent_win[st+i])) i++;
        if (i < len && (ent_win[st+i] == CH_PLUS || ent_win[st+i] == CH_MINUS)) begin
            neg = (ent_win[st+i] == CH_MINUS);
            i++;
        end
        // optional 0x only when a hex digit follows it
        if (base == 16 && i + 2 < len && ent_win[st+i] == "0"
            && (ent_win[st+i+1] == CH_LOW_X || ent_win[st+i+1] == CH_UP_X)
            && digit_of(ent_win[st+i+2]) < 16) begin
            i += 2;
        end
        while (i < len && digit_of(ent_win[st+i]) < base) begin
            v = v * base + digit_of(ent_win[st+i]);
            if (v > 32'h10000) v = 32'h10000;
            i++;
        end
        return v;
    endfunction

    // window holds '&', body and ';'; returns 1 when the entity is consumed
    function automatic bit resolve_entity(int n);
        int          len;
        bit          hit;
        bit          neg;
        int unsigned v;
        len = n - 2;
        for (int k = 0; k < 13; k++) begin
            if (ent_names[k].len() == len) begin
                hit = 1;
                for (int i = 0; i < len; i++)
                    if (ent_win[1+i] != ent_names[k][i]) hit = 0;
                if (hit) begin
                    put_text(ent_texts[k]);
                    return 1;
                end
            end
        end
        if (len >= 1 && ent_win[1] == CH_HASH) begin
            if (len >= 2 && (ent_win[2] == CH_LOW_X || ent_win[2] == CH_UP_X))
                v = read_number(3, len - 2, 16, neg);
            else
                v = read_number(2, len - 1, 10, neg);
            if (neg && v != 0) return 1;
            if (v >= 32'h20 && v <= 32'h7E) put_byte(v[7:0]);
            else if (v == 32'h2018 || v == 32'h2019) put_byte(CH_APOS);
            else if (v == 32'h201C || v == 32'h201D) put_byte(CH_DQUOTE);
            else if (v == 32'h2013) put_byte(CH_MINUS);
            else if (v == 32'h2014) put_text("--");
            else if (v == 32'h2026) put_text("...");
            else if (v == 32'hA0) put_byte(CH_SPACE);
            return 1;
        end
        return 0;
    endfunction

    // give up on the open entity: emit '&', queue the held bytes for rescan
    function automatic void abandon_entity();
        int cnt;
        cnt = ent_fill > 0 ? ent_fill - 1 : 0;
        put_byte(CH_AMP);
        if (cnt + rescan_cnt > WIN_DEPTH) cnt = WIN_DEPTH - rescan_cnt;
        for (int i = rescan_cnt - 1; i >= 0; i--) rescan_q[i+cnt] = rescan_q[i];
        for (int i = 0; i < cnt; i++) rescan_q[i] = ent_win[1+i];
        rescan_cnt += cnt;
        ent_fill = 0;
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        if (ent_fill == 0) begin
            if (b == CH_AMP) begin
                ent_win[0] = b;
                ent_fill = 1;
            end else begin
                put_byte(b);
            end
            return;
        end
        if (ent_fill >= WIN_DEPTH) begin
            abandon_entity();
            scan_byte(b);
            return;
        end
        ent_win[ent_fill] = b;
        ent_fill++;
        if (b == CH_SEMI) begin
            if (resolve_entity(ent_fill)) ent_fill = 0;
            else abandon_entity();
        end else if (ent_fill >= WIN_DEPTH) begin
            abandon_entity();
        end
    endfunction

    function automatic void flush_rescan();
        logic [7:0] b;
        while (rescan_cnt > 0) begin
            b = rescan_q[0];
            for (int i = 0; i < rescan_cnt - 1; i++) rescan_q[i] = rescan_q[i+1];
            rescan_cnt--;
            scan_byte(b);
        end
    endfunction

    // all words one accepted text byte causes, left in step_words
    function automatic void decode_byte(logic [7:0] b, logic last);
        t_word w;
        step_words.delete();
        scan_byte(b);
        flush_rescan();
        if (last) begin
            while (ent_fill > 0) begin
                abandon_entity();
                flush_rescan();
            end
            if (step_words.size() == 0) begin
                w.data = 8'h00;
                w.valid = 1'b0;
                w.done = 1'b1;
                step_words.push_back(w);
            end else begin
                step_words[step_words.size()-1].done = 1'b1;
            end
        end
    endfunction

    // typed answer of a whole directed row, done set on its last word
    function automatic void push_typed(string s);
        t_word w;
        if (s.len() == 0) begin
            w.data = 8'h00;
            w.valid = 1'b0;
            w.done = 1'b1;
            expected_words.push_back(w);
        end
        for (int i = 0; i < s.len(); i++) begin
            w.data = s[i];
            w.valid = 1'b1;
            w.done = (i == s.len() - 1);
            expected_words.push_back(w);
        end
    endfunction

    // ---------------------------------------------------------------
    // input side: predict on every accepted word
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            decode_byte(in_if.text_byte, in_if.end_of_text);
            if (row_sel >= 0 && dir_rows[row_sel].typed) begin
                // typed answer replaces the prediction, pushed on the first byte
                if (row_sel != typed_row) push_typed(dir_rows[row_sel].want);
            end else begin
                foreach (step_words[i]) expected_words.push_back(step_words[i]);
            end
            typed_row = row_sel;
        end
    end

    // ---------------------------------------------------------------
    // output side: compare every accepted word with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, got byte %h valid %b done %b", $realtime,
                         out_if.out_byte, out_if.byte_valid, out_if.text_done);
                error_count++;
            end else begin
                w = expected_words.pop_front();
                if (out_if.out_byte !== w.data || out_if.byte_valid !== w.valid
                    || out_if.text_done !== w.done) begin
                    $display("%0t: mismatch, expected byte %h valid %b done %b, got byte %h valid %b done %b",
                             $realtime, w.data, w.valid, w.done,
                             out_if.out_byte, out_if.byte_valid, out_if.text_done);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stalls, one long hold-off to back up the input
    // ---------------------------------------------------------------
    initial begin
        int gap;
        bit held;
        held = 0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 15);
            if (!held && words_seen >= 100) begin
                held = 1;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            words_seen++;
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------
    // offer one word; valid stays up after acceptance unless a gap follows
    task automatic send_word(logic [7:0] b, logic last, int row);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.text_byte   <= b;
        in_if.end_of_text <= last;
        row_sel           <= row;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // one random piece of text: plain byte, good entity or broken entity
    task automatic add_piece(ref logic [7:0] txt[$]);
        int    kind;
        int    n;
        string s;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                txt.push_back(8'($urandom_range(1, 255)));
            end
            3, 4: begin
                s = {"&", ent_names[$urandom_range(0, 12)], ";"};
                for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
            end
            5: begin
                // decimal, sometimes with blanks and a sign
                s = "&#";
                if ($urandom_range(0, 3) == 0) s = {s, " "};
                if ($urandom_range(0, 3) == 0) s = {s, $urandom_range(0, 1) ? "-" : "+"};
                case ($urandom_range(0, 3))
                    0: s = {s, $sformatf("%0d", $urandom_range(32, 126))};
                    1: s = {s, $sformatf("%0d", $urandom_range(8208, 8230))};
                    2: s = {s, "160"};
                    default: s = {s, $sformatf("%0d", $urandom_range(0, 999999))};
                endcase
                s = {s, ";"};
                for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
            end
            6: begin
                // hex, either x case, optional 0x, mixed digit case
                s = $urandom_range(0, 1) ? "&#x" : "&#X";
                if ($urandom_range(0, 2) == 0) s = {s, "0x"};
                case ($urandom_range(0, 2))
                    0: s = {s, $sformatf("%0h", $urandom_range(32, 126))};
                    1: s = {s, $sformatf("%0H", $urandom_range(16'h2010, 16'h2027))};
                    default: s = {s, $sformatf("%0h", $urandom_range(0, 20'hFFFFF))};
                endcase
                s = {s, ";"};
                for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
            end
            default: begin
                // broken: '&' then junk from the entity alphabet, maybe a ';'
                txt.push_back(CH_AMP);
                n = $urandom_range(0, 14);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 5))
                        0: txt.push_back(CH_SEMI);
                        1: txt.push_back(CH_AMP);
                        2: txt.push_back(CH_HASH);
                        3: txt.push_back(8'($urandom_range(8'h30, 8'h39)));
                        default: txt.push_back(8'($urandom_range(8'h61, 8'h7A)));
                    endcase
                end
            end
        endcase
    endtask

    initial begin
        logic [7:0] txt[$];
        int         sent;
        int         n_text;
        int         len;
        int         guard;
        error_count = 0;
        words_seen  = 0;
        idle_cycles = 0;
        typed_row   = -1;
        burst       = 0;
        ent_fill    = 0;
        rescan_cnt  = 0;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            ent_win[i]  = 8'h00;
            rescan_q[i] = 8'h00;
        end
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.text_byte   <= 8'h00;
        in_if.end_of_text <= 1'b0;
        row_sel           <= -1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed texts
        for (int r = 0; r < N_DIR; r++) begin
            len = dir_rows[r].txt.len();
            for (int i = 0; i < len; i++)
                send_word(dir_rows[r].txt[i], i == len - 1, r);
        end

        // random texts; a run of them goes with no gaps on either side
        sent = 0;
        n_text = 0;
        while (sent < RAND_ITEMS) begin
            txt.delete();
            len = $urandom_range(1, 30);
            while (txt.size() < len) add_piece(txt);
            burst = (n_text >= 1 && n_text <= 2);
            foreach (txt[i]) send_word(txt[i], i == txt.size() - 1, -1);
            sent += txt.size();
            n_text++;
        end
        burst = 0;
        in_if.valid <= 1'b0;

        // drain, then a short quiet spell to catch stray words
        while (expected_words.size() != 0) @(posedge i_clk);
        guard = 0;
        while (guard < 40) begin
            @(posedge i_clk);
            guard++;
        end
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
